[hdl/pwmt_pkg.sv]
// Shared types, constants and helpers of the PWM timer channel.
`default_nettype none

package pwmt_pkg;

    localparam int CNT_BITS = 16;
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int SET_W    = 16;
    localparam int CMP_W    = 16;
    localparam int P_W      = CNT_BITS + 1;
    localparam int DIV_W    = CNT_BITS + 33;
    localparam int DIV_STEPS = DATA_W;
    localparam int STEP_W   = $clog2(DIV_STEPS + 1);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int REG_IDX_W = 1;

    localparam logic [32:0] P_LIMIT = 33'd1 << CNT_BITS;
    localparam logic [CNT_BITS-1:0] PERIOD_RESET = CNT_BITS'(65535);
    localparam logic [DATA_W-1:0] CLOCK_RESET = 32'd48000000;

    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_ON   = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_FREQ = 3'd2;
    localparam logic [OP_W-1:0] OP_ENABLE   = 3'd3;
    localparam logic [OP_W-1:0] OP_DISABLE  = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_TIMER_CLOCK = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_INVERTED    = 1'b1;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_TICK,
        CLS_SET_ON,
        CLS_SET_FREQ,
        CLS_ENABLE,
        CLS_DISABLE
    } op_class_t;

    typedef struct packed {
        op_class_t          cls;
        logic [DATA_W-1:0]  value;
    } entry_t;

    typedef struct packed {
        logic               start;
        logic [DATA_W-1:0]  dividend;
        logic [DIV_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DATA_W-1:0]  quotient;
    } div_rsp_t;

    function automatic logic [SET_W-1:0] to_setting(input logic [CNT_BITS-1:0] x);
        logic [CNT_BITS+SET_W-1:0] ext;
        ext = {{SET_W{1'b0}}, x};
        return ext[SET_W-1:0];
    endfunction

    function automatic logic level_of(input logic enabled, input logic [CMP_W-1:0] cmp,
                                      input logic [CNT_BITS-1:0] cnt, input logic inv);
        logic [CNT_BITS+CMP_W-1:0] a;
        logic [CNT_BITS+CMP_W-1:0] b;
        a = {{CNT_BITS{1'b0}}, cmp};
        b = {{CMP_W{1'b0}}, cnt};
        return enabled & ((a > b) ^ inv);
    endfunction

endpackage

`default_nettype wire

[hdl/pwmt_if.sv]
// Command and result channel interfaces of the PWM timer channel.
`default_nettype none

interface pwmt_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [pwmt_pkg::OP_W-1:0]     operation;
    logic [pwmt_pkg::DATA_W-1:0]   value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

interface pwmt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          pwm_level;
    logic                          update_event;
    logic [pwmt_pkg::SET_W-1:0]    prescale_setting;
    logic [pwmt_pkg::SET_W-1:0]    period_setting;
    logic                          setup_error;

    modport source (output valid, output pwm_level, output update_event,
                    output prescale_setting, output period_setting,
                    output setup_error, input ready);
    modport sink (input valid, input pwm_level, input update_event,
                  input prescale_setting, input period_setting,
                  input setup_error, output ready);
endinterface

`default_nettype wire

[hdl/pwmt_front.sv]
// Command intake: decodes operations and queues them for the execution side.
`default_nettype none

module pwmt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    pwmt_cmd_if.sink               cmd,
    output pwmt_pkg::entry_t       head,
    output logic                   head_valid,
    input  wire logic              pop
);

    pwmt_pkg::entry_t                   q_reg [pwmt_pkg::QDEPTH];
    logic [pwmt_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [pwmt_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [pwmt_pkg::QCNT_W-1:0]        count_reg, count_next;
    pwmt_pkg::entry_t                   entry;
    logic                               push;

    function automatic pwmt_pkg::op_class_t classify(input logic [pwmt_pkg::OP_W-1:0] op);
        pwmt_pkg::op_class_t c;
        unique case (op)
            pwmt_pkg::OP_TICK:     c = pwmt_pkg::CLS_TICK;
            pwmt_pkg::OP_SET_ON:   c = pwmt_pkg::CLS_SET_ON;
            pwmt_pkg::OP_SET_FREQ: c = pwmt_pkg::CLS_SET_FREQ;
            pwmt_pkg::OP_ENABLE:   c = pwmt_pkg::CLS_ENABLE;
            pwmt_pkg::OP_DISABLE:  c = pwmt_pkg::CLS_DISABLE;
            default:               c = pwmt_pkg::CLS_NONE;
        endcase
        return c;
    endfunction

    assign cmd.ready  = (count_reg != pwmt_pkg::QCNT_W'(pwmt_pkg::QDEPTH));
    assign push       = cmd.valid && cmd.ready;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);

    always_comb
    begin
        entry.cls   = classify(cmd.operation);
        entry.value = cmd.value;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == pwmt_pkg::QPTR_W'(pwmt_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pwmt_pkg::QPTR_W'(pwmt_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + pwmt_pkg::QCNT_W'(push) - pwmt_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

[hdl/pwmt_divider.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module pwmt_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pwmt_pkg::div_req_t req,
    output pwmt_pkg::div_rsp_t     rsp
);

    logic [pwmt_pkg::DIV_W-1:0]    rem_reg;
    logic [pwmt_pkg::DATA_W-1:0]   quo_reg;
    logic [pwmt_pkg::DIV_W-1:0]    dsor_reg;
    logic [pwmt_pkg::STEP_W-1:0]   step_reg;
    logic                          done_reg;
    logic [pwmt_pkg::DIV_W:0]      trial;
    logic [pwmt_pkg::DIV_W:0]      diff;
    logic                          ge;

    assign trial = {rem_reg, quo_reg[pwmt_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, dsor_reg};
    assign ge    = (trial >= {1'b0, dsor_reg});

    assign rsp.busy     = (step_reg != '0);
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            step_reg <= pwmt_pkg::STEP_W'(pwmt_pkg::DIV_STEPS);
            done_reg <= 1'b0;
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - 1'b1;
            done_reg <= (step_reg == pwmt_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dsor_reg <= req.divisor;
        end
        else if (step_reg != '0)
        begin
            rem_reg <= ge ? diff[pwmt_pkg::DIV_W-1:0] : trial[pwmt_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[pwmt_pkg::DATA_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

[hdl/pwmt_back.sv]
// Execution side: counters, compare output, frequency setup and result register.
`default_nettype none

module pwmt_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire pwmt_pkg::entry_t          head,
    input  wire logic                      head_valid,
    output logic                           pop,
    input  wire logic [pwmt_pkg::DATA_W-1:0] timer_clock_hz,
    input  wire logic                      inverted,
    output pwmt_pkg::div_req_t             div_req,
    input  wire pwmt_pkg::div_rsp_t        div_rsp,
    pwmt_rsp_if.source                     rsp
);

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_DIV1 = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_DIV2 = 4'b1000
    } state_t;

    localparam int CB = pwmt_pkg::CNT_BITS;

    state_t                         state_reg, state_next;
    logic [CB-1:0]                  ps_cnt_reg, ps_cnt_next;
    logic [CB-1:0]                  pd_cnt_reg, pd_cnt_next;
    logic [CB-1:0]                  ps_act_reg, ps_act_next;
    logic [CB-1:0]                  pd_act_reg, pd_act_next;
    logic [CB-1:0]                  ps_pre_reg, ps_pre_next;
    logic [CB-1:0]                  pd_pre_reg, pd_pre_next;
    logic [pwmt_pkg::CMP_W-1:0]     cmp_reg, cmp_next;
    logic                           en_reg, en_next;
    logic [pwmt_pkg::DATA_W-1:0]    f_reg, f_next;
    logic [pwmt_pkg::P_W-1:0]       p_reg, p_next;
    logic                           p_err_reg, p_err_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           level_reg, upd_reg, err_reg;
    logic [pwmt_pkg::SET_W-1:0]     pre_set_reg, per_set_reg;
    logic                           out_free, fire, freq_bad;
    logic                           emit, emit_upd, emit_err;
    logic [32:0]                    p_wide;

    assign out_free = !out_valid_reg || rsp.ready;
    assign fire     = (state_reg == ST_RUN) && head_valid && out_free;
    assign freq_bad = (head.value == '0) || (head.value > timer_clock_hz);
    assign p_wide   = 33'(div_rsp.quotient >> CB) + 33'd1;

    assign rsp.valid            = out_valid_reg;
    assign rsp.pwm_level        = level_reg;
    assign rsp.update_event     = upd_reg;
    assign rsp.prescale_setting = pre_set_reg;
    assign rsp.period_setting   = per_set_reg;
    assign rsp.setup_error      = err_reg;

    always_comb
    begin
        state_next  = state_reg;
        ps_cnt_next = ps_cnt_reg;
        pd_cnt_next = pd_cnt_reg;
        ps_act_next = ps_act_reg;
        pd_act_next = pd_act_reg;
        ps_pre_next = ps_pre_reg;
        pd_pre_next = pd_pre_reg;
        cmp_next    = cmp_reg;
        en_next     = en_reg;
        f_next      = f_reg;
        p_next      = p_reg;
        p_err_next  = p_err_reg;
        pop         = 1'b0;
        emit        = 1'b0;
        emit_upd    = 1'b0;
        emit_err    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = timer_clock_hz;
        div_req.divisor  = pwmt_pkg::DIV_W'(head.value);

        unique case (state_reg)
            ST_RUN:
            begin
                if (fire)
                begin
                    pop  = 1'b1;
                    emit = 1'b1;
                    unique case (head.cls)
                        pwmt_pkg::CLS_TICK:
                        begin
                            if (ps_cnt_reg >= ps_act_reg)
                            begin
                                ps_cnt_next = '0;
                                if (pd_cnt_reg >= pd_act_reg)
                                begin
                                    pd_cnt_next = '0;
                                    ps_act_next = ps_pre_reg;
                                    pd_act_next = pd_pre_reg;
                                    emit_upd    = 1'b1;
                                end
                                else
                                begin
                                    pd_cnt_next = pd_cnt_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                ps_cnt_next = ps_cnt_reg + 1'b1;
                            end
                        end
                        pwmt_pkg::CLS_SET_ON:
                        begin
                            cmp_next    = head.value[pwmt_pkg::CMP_W-1:0];
                            ps_cnt_next = '0;
                            pd_cnt_next = '0;
                            ps_act_next = ps_pre_reg;
                            pd_act_next = pd_pre_reg;
                            emit_upd    = 1'b1;
                        end
                        pwmt_pkg::CLS_SET_FREQ:
                        begin
                            if (freq_bad)
                            begin
                                emit_err = 1'b1;
                            end
                            else
                            begin
                                emit          = 1'b0;
                                f_next        = head.value;
                                div_req.start = 1'b1;
                                state_next    = ST_DIV1;
                            end
                        end
                        pwmt_pkg::CLS_ENABLE:  en_next = 1'b1;
                        pwmt_pkg::CLS_DISABLE: en_next = 1'b0;
                        pwmt_pkg::CLS_NONE:    en_next = en_reg;
                        default:               en_next = en_reg;
                    endcase
                end
            end
            ST_DIV1:
            begin
                if (div_rsp.done)
                begin
                    p_next     = pwmt_pkg::P_W'(p_wide);
                    p_err_next = (p_wide > pwmt_pkg::P_LIMIT);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (p_err_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_err   = 1'b1;
                        state_next = ST_RUN;
                    end
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.divisor = pwmt_pkg::DIV_W'(p_reg) * pwmt_pkg::DIV_W'(f_reg);
                    state_next      = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_rsp.done && out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_RUN;
                    if (div_rsp.quotient == '0)
                    begin
                        emit_err = 1'b1;
                    end
                    else
                    begin
                        ps_pre_next = CB'(p_reg - pwmt_pkg::P_W'(1));
                        pd_pre_next = CB'(div_rsp.quotient - 32'd1);
                    end
                end
            end
            default: state_next = ST_RUN;
        endcase

        out_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            ps_cnt_reg    <= '0;
            pd_cnt_reg    <= '0;
            ps_act_reg    <= '0;
            pd_act_reg    <= pwmt_pkg::PERIOD_RESET;
            ps_pre_reg    <= '0;
            pd_pre_reg    <= pwmt_pkg::PERIOD_RESET;
            cmp_reg       <= '0;
            en_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ps_cnt_reg    <= ps_cnt_next;
            pd_cnt_reg    <= pd_cnt_next;
            ps_act_reg    <= ps_act_next;
            pd_act_reg    <= pd_act_next;
            ps_pre_reg    <= ps_pre_next;
            pd_pre_reg    <= pd_pre_next;
            cmp_reg       <= cmp_next;
            en_reg        <= en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg      <= f_next;
        p_reg      <= p_next;
        p_err_reg  <= p_err_next;
        if (emit)
        begin
            level_reg   <= pwmt_pkg::level_of(en_next, cmp_next, pd_cnt_next, inverted);
            upd_reg     <= emit_upd;
            err_reg     <= emit_err;
            pre_set_reg <= pwmt_pkg::to_setting(ps_pre_next);
            per_set_reg <= pwmt_pkg::to_setting(pd_pre_next);
        end
    end

    a_ps_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ps_cnt_reg <= ps_act_reg)
        else $error("prescale counter beyond active prescaler");

    a_pd_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pd_cnt_reg <= pd_act_reg)
        else $error("period counter beyond active reload");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> !pop)
        else $error("queue popped during frequency setup");

    a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider started without waiting for it");

    a_err_no_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_reg) |-> !upd_reg)
        else $error("setup error reported with update event");

endmodule

`default_nettype wire

[hdl/pwm_timer_channel_with_freq_setup_core.sv]
// Top level of the PWM timer channel with frequency setup.
//
// Usage: operations enter on cmd (valid/ready) and each yields exactly one
// result transfer on rsp (valid/ready), in order. The configuration port
// (write_enable, reg_index, write_data) sets the timer clock rate
// (index 0) and output polarity (index 1); write it only while idle.
// A command is queued in a two-entry buffer; the execution side takes it
// from the queue head and registers its result. Tick, set on-clocks,
// enable, disable and unknown codes go one item per cycle sustained while
// rsp accepts and no frequency setup runs. A frequency request runs the
// shared restoring divider twice with a multiply step between, during
// which later items wait in the queue. Zero or above-clock requests return
// with setup_error set without dividing, as do those needing a prescaler
// above 65536 or giving a zero period. A stalled rsp holds its result; the
// queue keeps taking commands until it fills, then cmd.ready drops. Reset
// empties the queue, clears counters and compare value, and loads period
// 65535, 48 MHz, normal polarity, output disabled; no clearing pass.
`default_nettype none

module pwm_timer_channel_with_freq_setup_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    pwmt_cmd_if.sink                               cmd,
    pwmt_rsp_if.source                             rsp,
    input  wire logic                              write_enable,
    input  wire logic [pwmt_pkg::REG_IDX_W-1:0]    reg_index,
    input  wire logic [pwmt_pkg::DATA_W-1:0]       write_data
);

    logic [pwmt_pkg::DATA_W-1:0]   timer_clock_hz_reg;
    logic                          inverted_reg;
    pwmt_pkg::entry_t              head;
    logic                          head_valid;
    logic                          pop;
    pwmt_pkg::div_req_t            div_req;
    pwmt_pkg::div_rsp_t            div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clock_hz_reg <= pwmt_pkg::CLOCK_RESET;
            inverted_reg       <= 1'b0;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                pwmt_pkg::REG_TIMER_CLOCK: timer_clock_hz_reg <= write_data;
                pwmt_pkg::REG_INVERTED:    inverted_reg       <= write_data[0];
                default:                   inverted_reg       <= inverted_reg;
            endcase
        end
    end

    pwmt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    pwmt_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pwmt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop),
        .timer_clock_hz (timer_clock_hz_reg),
        .inverted       (inverted_reg),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .rsp            (rsp)
    );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Testbench for the PWM timer channel: directed and random operations checked against a predictor.
`timescale 1ns / 100ps

module testbench;

    localparam logic [pwmt_pkg::OP_W-1:0] OP_FIRST_SPARE =
        pwmt_pkg::OP_W'(pwmt_pkg::OP_DISABLE + 1);
    localparam logic [pwmt_pkg::OP_W-1:0] OP_LAST_SPARE  = '1;
    localparam longint unsigned COUNTER_RANGE = longint'(1) << pwmt_pkg::CNT_BITS;
    localparam int PHASE_ITEMS = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                        pwm_level;
        logic                        update_event;
        logic [pwmt_pkg::SET_W-1:0]  prescale_setting;
        logic [pwmt_pkg::SET_W-1:0]  period_setting;
        logic                        setup_error;
    } pwm_result_t;

    class pwm_scoreboard;
        logic [pwmt_pkg::DATA_W-1:0]   timer_clock_hz;
        logic                          inverted;
        logic [pwmt_pkg::CNT_BITS-1:0] prescale_count;
        logic [pwmt_pkg::CNT_BITS-1:0] period_count;
        logic [pwmt_pkg::CNT_BITS-1:0] prescale_active;
        logic [pwmt_pkg::CNT_BITS-1:0] period_active;
        logic [pwmt_pkg::CNT_BITS-1:0] prescale_preload;
        logic [pwmt_pkg::CNT_BITS-1:0] period_preload;
        logic [pwmt_pkg::CMP_W-1:0]    compare_value;
        logic                          output_enabled;
        pwm_result_t                   expected_results[$];
        int                            failures;

        function new();
            timer_clock_hz   = pwmt_pkg::CLOCK_RESET;
            inverted         = 1'b0;
            prescale_count   = '0;
            period_count     = '0;
            prescale_active  = '0;
            period_active    = pwmt_pkg::PERIOD_RESET;
            prescale_preload = '0;
            period_preload   = pwmt_pkg::PERIOD_RESET;
            compare_value    = '0;
            output_enabled   = 1'b0;
            failures         = 0;
        endfunction

        function void load_register(logic [pwmt_pkg::REG_IDX_W-1:0] idx,
                                    logic [pwmt_pkg::DATA_W-1:0] data);
            if (idx == pwmt_pkg::REG_TIMER_CLOCK)
                timer_clock_hz = data;
            else if (idx == pwmt_pkg::REG_INVERTED)
                inverted = data[0];
        endfunction

        function void load_active();
            prescale_active = prescale_preload;
            period_active   = period_preload;
        endfunction

        // prescaler of (clock / f) / 65536 + 1, which keeps the period within the counter range
        function bit compute_dividers(logic [pwmt_pkg::DATA_W-1:0] f);
            longint unsigned base;
            longint unsigned freq;
            longint unsigned p;
            longint unsigned per;
            base = timer_clock_hz;
            freq = f;
            if (freq == 0 || freq > base)
                return 1'b0;
            p = (base / freq) / COUNTER_RANGE + 1;
            if (p > COUNTER_RANGE)
                return 1'b0;
            per = base / (p * freq);
            if (per == 0)
                return 1'b0;
            prescale_preload = pwmt_pkg::CNT_BITS'(p - 1);
            period_preload   = pwmt_pkg::CNT_BITS'(per - 1);
            return 1'b1;
        endfunction

        function void note_command(logic [pwmt_pkg::OP_W-1:0] op,
                                   logic [pwmt_pkg::DATA_W-1:0] value);
            pwm_result_t r;
            r = '0;
            case (op)
                pwmt_pkg::OP_TICK:
                begin
                    if (prescale_count >= prescale_active)
                    begin
                        prescale_count = '0;
                        if (period_count >= period_active)
                        begin
                            period_count = '0;
                            load_active();
                            r.update_event = 1'b1;
                        end
                        else
                            period_count = period_count + 1'b1;
                    end
                    else
                        prescale_count = prescale_count + 1'b1;
                end
                pwmt_pkg::OP_SET_ON:
                begin
                    compare_value  = value[pwmt_pkg::CMP_W-1:0];
                    prescale_count = '0;
                    period_count   = '0;
                    load_active();
                    r.update_event = 1'b1;
                end
                pwmt_pkg::OP_SET_FREQ: r.setup_error = !compute_dividers(value);
                pwmt_pkg::OP_ENABLE:   output_enabled = 1'b1;
                pwmt_pkg::OP_DISABLE:  output_enabled = 1'b0;
                default: ;
            endcase
            r.pwm_level = output_enabled & ((compare_value > period_count) ^ inverted);
            r.prescale_setting = prescale_preload;
            r.period_setting   = period_preload;
            expected_results.push_back(r);
        endfunction

        function void check_result(pwm_result_t got);
            pwm_result_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result %p", $realtime, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.pwm_level !== want.pwm_level || got.update_event !== want.update_event ||
                got.prescale_setting !== want.prescale_setting ||
                got.period_setting !== want.period_setting ||
                got.setup_error !== want.setup_error)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            write_enable;
    logic [pwmt_pkg::REG_IDX_W-1:0]  reg_index;
    logic [pwmt_pkg::DATA_W-1:0]     write_data;

    pwmt_cmd_if cmd_ch ();
    pwmt_rsp_if rsp_ch ();

    pwm_timer_channel_with_freq_setup_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_ch),
        .rsp          (rsp_ch),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    pwm_scoreboard sb = new();
    int  send_left = 0;
    bit  send_calm = 1'b0;
    int  recv_left = 0;
    bit  recv_calm = 1'b0;
    int  results_seen = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int draw_wait(ref int left, ref bit calm);
        if (left == 0)
        begin
            left = $urandom_range(10, 60);
            calm = ($urandom_range(0, 2) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [pwmt_pkg::DATA_W-1:0] pick_frequency(
        logic [pwmt_pkg::DATA_W-1:0] clock_hz);
        logic [pwmt_pkg::DATA_W-1:0] f;
        case ($urandom_range(0, 7))
            0: f = '0;
            1: f = $urandom;
            2: f = clock_hz + $urandom_range(1, 1000);
            3: f = pwmt_pkg::DATA_W'(clock_hz / (COUNTER_RANGE * $urandom_range(1, 4)));
            default: f = clock_hz / $urandom_range(1, 40);
        endcase
        return f;
    endfunction

    function automatic logic [pwmt_pkg::DATA_W-1:0] pick_on_clocks();
        logic [pwmt_pkg::DATA_W-1:0] v;
        if ($urandom_range(0, 4) == 0)
            v = $urandom;
        else
        begin
            v = $urandom_range(0, int'(sb.period_preload) + 2);
            if ($urandom_range(0, 1) == 1)
                v[pwmt_pkg::DATA_W-1:pwmt_pkg::CMP_W] =
                    (pwmt_pkg::DATA_W - pwmt_pkg::CMP_W)'($urandom);
        end
        return v;
    endfunction

    task automatic send_command(input logic [pwmt_pkg::OP_W-1:0] op,
                                input logic [pwmt_pkg::DATA_W-1:0] value);
        int gap;
        gap = draw_wait(send_left, send_calm);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid     = 1'b1;
        cmd_ch.operation = op;
        cmd_ch.value     = value;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        sb.note_command(op, value);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [pwmt_pkg::REG_IDX_W-1:0] idx,
                                  input logic [pwmt_pkg::DATA_W-1:0] data);
        write_enable = 1'b1;
        reg_index    = idx;
        write_data   = data;
        @(negedge clk);
        write_enable = 1'b0;
        sb.load_register(idx, data);
    endtask

    task automatic wait_idle();
        cmd_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [pwmt_pkg::DATA_W-1:0] clock_hz, input logic inv,
                             input int n);
        int sent;
        int pick;
        wait_idle();
        write_register(pwmt_pkg::REG_TIMER_CLOCK, clock_hz);
        write_register(pwmt_pkg::REG_INVERTED, {{(pwmt_pkg::DATA_W-1){1'b0}}, inv});
        send_command(pwmt_pkg::OP_SET_FREQ, pick_frequency(clock_hz));
        send_command(pwmt_pkg::OP_SET_ON, pick_on_clocks());
        send_command(pwmt_pkg::OP_ENABLE, $urandom);
        sent = 3;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                send_command(pwmt_pkg::OP_TICK, $urandom);
            else if (pick < 80)
            begin
                send_command(pwmt_pkg::OP_SET_FREQ, pick_frequency(clock_hz));
                if ($urandom_range(0, 3) != 0)
                begin
                    send_command(pwmt_pkg::OP_SET_ON, pick_on_clocks());
                    sent++;
                end
            end
            else if (pick < 86)
                send_command(pwmt_pkg::OP_SET_ON, pick_on_clocks());
            else if (pick < 91)
                send_command(pwmt_pkg::OP_ENABLE, $urandom);
            else if (pick < 96)
                send_command(pwmt_pkg::OP_DISABLE, $urandom);
            else
                send_command(pwmt_pkg::OP_W'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE)),
                             $urandom);
            sent++;
        end
    endtask

    // result side; holds off for a long stretch twice so the command queue backs up
    initial
    begin
        int stall;
        pwm_result_t got;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(recv_left, recv_calm);
            if (results_seen == 450 || results_seen == 1050)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            got.pwm_level        = rsp_ch.pwm_level;
            got.update_event     = rsp_ch.update_event;
            got.prescale_setting = rsp_ch.prescale_setting;
            got.period_setting   = rsp_ch.period_setting;
            got.setup_error      = rsp_ch.setup_error;
            sb.check_result(got);
            results_seen++;
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        write_enable     = 1'b0;
        reg_index        = '0;
        write_data       = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = '0;
        cmd_ch.value     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: 48 MHz clock, normal polarity
        send_command(pwmt_pkg::OP_TICK, '0);
        send_command(pwmt_pkg::OP_ENABLE, '0);
        send_command(pwmt_pkg::OP_TICK, '1);
        send_command(pwmt_pkg::OP_SET_FREQ, '0);
        send_command(pwmt_pkg::OP_SET_FREQ, 32'd48_000_001);
        send_command(pwmt_pkg::OP_SET_FREQ, '1);
        send_command(pwmt_pkg::OP_SET_FREQ, 32'd1);
        send_command(pwmt_pkg::OP_SET_FREQ, 32'd48_000_000);
        send_command(pwmt_pkg::OP_SET_ON, 32'hFFFF_0003);
        repeat (3) send_command(pwmt_pkg::OP_TICK, '0);
        send_command(pwmt_pkg::OP_SET_FREQ, 32'd12_000_000);
        send_command(pwmt_pkg::OP_SET_ON, 32'h0000_FFFF);
        send_command(pwmt_pkg::OP_SET_ON, 32'd2);
        repeat (5) send_command(pwmt_pkg::OP_TICK, '0);
        send_command(pwmt_pkg::OP_DISABLE, '1);
        send_command(pwmt_pkg::OP_TICK, '0);
        send_command(OP_FIRST_SPARE, '1);
        send_command(pwmt_pkg::OP_W'(OP_FIRST_SPARE + 1), '1);
        send_command(OP_LAST_SPARE, '1);

        run_phase(32'd1000, 1'b1, PHASE_ITEMS);
        run_phase(32'd1, 1'b0, PHASE_ITEMS);
        run_phase('1, 1'b1, PHASE_ITEMS);
        run_phase(pwmt_pkg::CLOCK_RESET, 1'b0, PHASE_ITEMS);
        run_phase($urandom_range(2, 100000), 1'($urandom_range(0, 1)), PHASE_ITEMS);
        run_phase($urandom, 1'($urandom_range(0, 1)), PHASE_ITEMS);

        cmd_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
